// File: design/ccpa_pkg.sv
package ccpa_pkg;

    // Field widths of the stream items and of the limit register.
    localparam int LIMIT_W  = 11;
    localparam int HEAD_W   = 10;
    localparam int LEN_W    = 3;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    localparam logic [LEN_W-1:0]   MAX_CHAIN = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // Cells taken by each attribute group of an allocation.
    localparam logic [LEN_W-1:0] RGB_CELLS   = 3'd3;
    localparam logic [LEN_W-1:0] ALPHA_CELLS = 3'd1;
    localparam logic [LEN_W-1:0] STW_CELLS   = 3'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_DONE
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_CELLS = 2'd1,
        ST_BAD_CELL = 2'd2
    } t_status;

    // Result payload, first member in the highest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] cells_free;
        logic [LEN_W-1:0]   chain_length;
        logic [HEAD_W-1:0]  head_index;
        logic               head_valid;
    } t_result;

endpackage

// File: design/ccpa_link_ram.sv
module ccpa_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // A read of the entry being written in the same cycle returns the new value.
    always_ff @(posedge i_clk) begin
        r_fwd      <= i_we && (i_waddr == i_raddr);
        r_fwd_data <= i_wdata;
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

// File: design/chained_cell_pool_allocator_unit.sv
// Cell pool allocator: hands out cells of a pool as linked chains and takes them back.
// Input items arrive on the s_axis group: tuser carries the action (allocate or free),
// tdata the wanted attribute groups and, for a free, the head of the chain to return.
// Every item gives exactly one result item on the m_axis group: tuser carries the status,
// tdata the head of a new chain, the chain length and the free cell count afterwards.
// The limit register is written through i_cfg_we/i_cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. A write clamps the
// value to 1..POOL_DEPTH and empties the pool again. Chain links live in one synchronous
// link memory. An allocation links its cells from the free list, with an extra step
// whenever it must first read the free-list head, or else from the bump pointer; a free
// walks one cell per cycle. Each item is accepted in S_IDLE, worked on, if it needs work,
// in S_ALLOC or S_FREE, and handed over to the output register from S_DONE.
// s_axis_tready is high only while no item is in progress. A finished result waits in
// the output register, so the next item is accepted and worked on while the receiver
// stalls; the block only holds a second finished result until that register is free.
// After reset the pool is empty of chains, the limit is the smaller of 1024 and
// POOL_DEPTH and no result is pending; the link memory needs no clearing pass.
module chained_cell_pool_allocator_unit #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: pool_limit.
    input  logic                             i_cfg_we,
    input  logic [ccpa_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    // tdata: want_rgb, want_alpha, want_stw, chain_present, chain_head[9:0], two zero bits.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ccpa_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: action.
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: head_valid, head_index[9:0], chain_length[2:0], cells_free[10:0], zero bits.
    output logic [ccpa_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // tuser: status[1:0].
    output logic [ccpa_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import ccpa_pkg::*;

    localparam int IW   = $clog2(POOL_DEPTH);
    localparam int LW   = $clog2(POOL_DEPTH + 1);
    localparam int CMPW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int RST_LIMIT = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;

    localparam logic [LW-1:0]      NULL_L   = LW'(POOL_DEPTH);
    localparam logic [CMPW-1:0]    DEPTH_C  = CMPW'(POOL_DEPTH);
    localparam logic [LIMIT_W-1:0] RST_LIM  = LIMIT_W'(RST_LIMIT);

    function automatic logic [LW-1:0] clean_link(input logic [LW-1:0] v);
        return (v < NULL_L) ? v : NULL_L;
    endfunction

    t_state                r_state, n_state;
    logic [LIMIT_W-1:0]    r_limit, n_limit;
    logic [LW-1:0]         r_free_head, n_free_head;
    logic [LW-1:0]         r_used, n_used;
    logic [COUNT_W-1:0]    r_free_total, n_free_total;
    logic [LW-1:0]         r_chain, n_chain;
    logic [IW-1:0]         r_cur, n_cur;
    logic [LEN_W-1:0]      r_left, n_left;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_rd_pend, n_rd_pend;
    logic                  r_is_alloc, n_is_alloc;
    t_status               r_status, n_status;
    t_result               r_out, n_out;
    t_status               r_out_status, n_out_status;
    logic                  r_ovalid, n_ovalid;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [LW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [LW-1:0]         ram_rdata;

    logic                  s_fire;
    logic                  in_rgb, in_alpha, in_stw, in_present;
    logic [HEAD_W-1:0]     in_head;
    logic [LEN_W-1:0]      want;
    logic [LW-1:0]         link_val;
    logic [LIMIT_W-1:0]    lim_clamped;
    logic                  start_alloc, start_free, work_done, out_free, out_load;
    logic [LW-1:0]         head_full;

    ccpa_link_ram #(
        .DEPTH (POOL_DEPTH),
        .AW    (IW),
        .DW    (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_rgb        = s_axis_tdata[0];
    assign in_alpha      = s_axis_tdata[1];
    assign in_stw        = s_axis_tdata[2];
    assign in_present    = s_axis_tdata[3];
    assign in_head       = s_axis_tdata[13:4];
    assign want          = (in_rgb ? RGB_CELLS : 3'd0) + (in_alpha ? ALPHA_CELLS : 3'd0)
                         + (in_stw ? STW_CELLS : 3'd0);
    assign link_val      = clean_link(ram_rdata);
    assign out_free      = !r_ovalid || m_axis_tready;
    assign out_load      = (r_state == S_DONE) && out_free;
    assign start_alloc   = s_fire && (s_axis_tuser == ACT_ALLOC) && (want != 3'd0)
                         && ({8'd0, want} <= r_free_total);
    assign start_free    = s_fire && (s_axis_tuser == ACT_FREE) && in_present
                         && (CMPW'(in_head) < CMPW'(r_used));
    assign head_full     = LW'(r_cur);

    always_comb begin
        lim_clamped = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            lim_clamped = LIMIT_W'(1);
        end else if (CMPW'(i_cfg_wdata) > DEPTH_C) begin
            lim_clamped = LIMIT_W'(DEPTH_C);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start_alloc) begin
                    n_state = S_ALLOC;
                end else if (start_free) begin
                    n_state = S_FREE;
                end else if (s_fire) begin
                    n_state = S_DONE;
                end
            end
            S_ALLOC, S_FREE: begin
                if (work_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, link memory accesses and result.
    always_comb begin
        n_limit      = r_limit;
        n_free_head  = r_free_head;
        n_used       = r_used;
        n_free_total = r_free_total;
        n_chain      = r_chain;
        n_cur        = r_cur;
        n_left       = r_left;
        n_len        = r_len;
        n_rd_pend    = r_rd_pend;
        n_is_alloc   = r_is_alloc;
        n_status     = r_status;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_ovalid     = r_ovalid && !m_axis_tready;
        work_done    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = r_chain;
        ram_raddr    = r_free_head[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_len      = '0;
                    n_status   = ST_OK;
                    n_chain    = NULL_L;
                    n_rd_pend  = 1'b0;
                    n_is_alloc = (s_axis_tuser == ACT_ALLOC);
                    n_left     = want;
                    n_cur      = IW'(in_head);
                    ram_raddr  = IW'(in_head);
                    if (s_axis_tuser == ACT_ALLOC) begin
                        if ({8'd0, want} > r_free_total) begin
                            n_status = ST_NO_CELLS;
                        end
                    end else if (in_present && !start_free) begin
                        n_status = ST_BAD_CELL;
                    end
                end
            end
            S_ALLOC: begin
                if (r_rd_pend) begin
                    // Free-list head read is back: link the cell and advance the list.
                    ram_we       = 1'b1;
                    ram_waddr    = r_free_head[IW-1:0];
                    ram_wdata    = r_chain;
                    n_chain      = r_free_head;
                    n_free_head  = link_val;
                    n_len        = r_len + 3'd1;
                    n_left       = r_left - 3'd1;
                    n_free_total = (r_free_total != '0) ? r_free_total - 11'd1 : r_free_total;
                    n_rd_pend    = 1'b0;
                    if (r_left == 3'd1) begin
                        work_done = 1'b1;
                    end else if (link_val != NULL_L) begin
                        ram_raddr = link_val[IW-1:0];
                        n_rd_pend = 1'b1;
                    end
                end else if (r_free_head != NULL_L) begin
                    n_rd_pend = 1'b1;
                end else if (CMPW'(r_used) < CMPW'(r_limit)) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_used[IW-1:0];
                    ram_wdata    = r_chain;
                    n_chain      = r_used;
                    n_used       = r_used + LW'(1);
                    n_len        = r_len + 3'd1;
                    n_left       = r_left - 3'd1;
                    n_free_total = (r_free_total != '0) ? r_free_total - 11'd1 : r_free_total;
                    work_done    = (r_left == 3'd1);
                end else begin
                    // Only reachable once a double free has corrupted the count.
                    n_status  = ST_NO_CELLS;
                    work_done = 1'b1;
                end
            end
            S_FREE: begin
                ram_we       = 1'b1;
                ram_waddr    = r_cur;
                ram_wdata    = r_free_head;
                n_free_head  = head_full;
                n_free_total = (r_free_total != COUNT_MAX) ? r_free_total + 11'd1
                                                           : r_free_total;
                n_len        = r_len + 3'd1;
                if ((link_val == NULL_L) || (r_len == MAX_CHAIN - 3'd1)) begin
                    work_done = 1'b1;
                end else if (CMPW'(link_val) >= CMPW'(r_used)) begin
                    n_status  = ST_BAD_CELL;
                    work_done = 1'b1;
                end else begin
                    ram_raddr = link_val[IW-1:0];
                    n_cur     = link_val[IW-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid                = 1'b1;
                    n_out_status            = r_status;
                    n_out.head_valid        = r_is_alloc && (r_len != '0);
                    n_out.head_index        = (r_is_alloc && (r_len != '0)) ? HEAD_W'(r_chain)
                                                                           : '0;
                    n_out.chain_length      = r_len;
                    n_out.cells_free        = r_free_total;
                end
            end
            default: ;
        endcase

        if (i_cfg_we) begin
            n_limit      = lim_clamped;
            n_free_head  = NULL_L;
            n_used       = '0;
            n_free_total = COUNT_W'(lim_clamped);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= RST_LIM;
            r_free_head  <= NULL_L;
            r_used       <= '0;
            r_free_total <= COUNT_W'(RST_LIM);
            r_rd_pend    <= 1'b0;
            r_len        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_limit      <= n_limit;
            r_free_head  <= n_free_head;
            r_used       <= n_used;
            r_free_total <= n_free_total;
            r_rd_pend    <= n_rd_pend;
            r_len        <= n_len;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chain      <= n_chain;
        r_cur        <= n_cur;
        r_left       <= n_left;
        r_is_alloc   <= n_is_alloc;
        r_status     <= n_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = M_DATA_W'({r_out.cells_free, r_out.chain_length,
                                      r_out.head_index, r_out.head_valid});
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_used_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_used) <= CMPW'(r_limit))
        else $error("bump pointer passed the pool limit");

    a_pend_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_ALLOC))
        else $error("free-list read pending outside an allocation");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FREE) || (r_state == S_ALLOC)) |-> (r_len < MAX_CHAIN))
        else $error("chain work went past seven cells");

    a_result_handed_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (m_axis_tvalid && s_axis_tready))
        else $error("finished result not presented");
`endif

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccpa_pkg::*;

    localparam int POOL_CELLS   = 1024;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 40;
    localparam int HEAD_KEEP    = 48;
    localparam logic [LIMIT_W-1:0] NULL_SLOT = LIMIT_W'(POOL_CELLS);

    // One request item; the low 14 bits match the s_axis tdata layout.
    typedef struct packed {
        logic              action;
        logic [HEAD_W-1:0] chain_head;
        logic              chain_present;
        logic              want_stw;
        logic              want_alpha;
        logic              want_rgb;
    } cell_req_t;

    typedef struct {
        t_status status;
        t_result body;
    } cell_reply_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LIMIT_W-1:0]    i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Shadow of the allocator state.
    logic [LIMIT_W-1:0]    link_mem [POOL_CELLS];
    logic [LIMIT_W-1:0]    free_top;
    logic [LIMIT_W-1:0]    bump_next;
    logic [LIMIT_W-1:0]    pool_cap;
    logic [COUNT_W-1:0]    free_count;

    cell_req_t             request_q [$];
    cell_reply_t           reply_q [$];
    logic [HEAD_W-1:0]     live_heads [$];
    logic [HEAD_W-1:0]     freed_heads [$];

    cell_req_t             drive_req;
    cell_req_t             bus_req;
    cell_reply_t           predicted;
    cell_reply_t           oldest;
    t_result               got_body;

    bit                    in_taken;
    bit                    hold_off;
    int                    gap_left;
    int                    burst_left;
    int unsigned           ready_tick;
    logic [15:0]           stall_pat;

    int queued_total, accepted_total, results_seen, error_count, cycle_count;
    int n_alloc, n_free, n_refused, n_partial, n_bad, n_capped, n_saturated;
    int limit_writes;

    chained_cell_pool_allocator_unit #(
        .POOL_DEPTH(POOL_CELLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LIMIT_W-1:0] tidy_link(input logic [LIMIT_W-1:0] v);
        return (v < NULL_SLOT) ? v : NULL_SLOT;
    endfunction

    function automatic void empty_pool();
        free_top   = NULL_SLOT;
        bump_next  = '0;
        free_count = pool_cap;
    endfunction

    // Works out the reply to one request and updates the shadow state.
    function automatic cell_reply_t serve_request(input cell_req_t r);
        cell_reply_t       e;
        logic [LEN_W-1:0]  want;
        logic [LEN_W-1:0]  n;
        logic [LIMIT_W-1:0] slot, chain, cur, nxt;
        e.status = ST_OK;
        e.body   = '0;
        n        = '0;
        if (r.action == ACT_ALLOC) begin
            want = '0;
            if (r.want_rgb)   want += RGB_CELLS;
            if (r.want_alpha) want += ALPHA_CELLS;
            if (r.want_stw)   want += STW_CELLS;
            if (COUNT_W'(want) > free_count) begin
                e.status = ST_NO_CELLS;
            end else begin
                chain = NULL_SLOT;
                while (n < want) begin
                    if (free_top != NULL_SLOT) begin
                        slot     = free_top;
                        free_top = tidy_link(link_mem[slot]);
                    end else if (bump_next < pool_cap) begin
                        slot      = bump_next;
                        bump_next = bump_next + 1'b1;
                    end else begin
                        // Only reachable once a double free has inflated the count.
                        e.status = ST_NO_CELLS;
                        break;
                    end
                    if (free_count != '0) free_count = free_count - 1'b1;
                    link_mem[slot] = chain;
                    chain = slot;
                    n = n + 1'b1;
                end
                if (n != '0) begin
                    e.body.head_valid = 1'b1;
                    e.body.head_index = chain[HEAD_W-1:0];
                end
            end
        end else if (r.chain_present) begin
            cur = {1'b0, r.chain_head};
            while (n < MAX_CHAIN) begin
                if (cur >= bump_next) begin
                    e.status = ST_BAD_CELL;
                    break;
                end
                nxt = tidy_link(link_mem[cur]);
                link_mem[cur] = free_top;
                free_top = cur;
                if (free_count < COUNT_MAX) free_count = free_count + 1'b1;
                n = n + 1'b1;
                if (nxt == NULL_SLOT) break;
                cur = nxt;
            end
        end
        e.body.chain_length = n;
        e.body.cells_free   = free_count;
        return e;
    endfunction

    function automatic cell_req_t alloc_req(input bit rgb, input bit alpha, input bit stw);
        cell_req_t r;
        r = '0;
        r.action     = ACT_ALLOC;
        r.want_rgb   = rgb;
        r.want_alpha = alpha;
        r.want_stw   = stw;
        return r;
    endfunction

    function automatic cell_req_t free_req(input bit present, input int head);
        cell_req_t r;
        r = '0;
        r.action        = ACT_FREE;
        r.chain_present = present;
        r.chain_head    = HEAD_W'(head);
        return r;
    endfunction

    // Allocations and frees of live chains; a noise_pct share are double frees, stray heads and frees with no chain.
    function automatic cell_req_t pick_request(input int noise_pct, input int hammer);
        cell_req_t r;
        int        roll, alloc_pct, idx;
        roll      = $urandom_range(0, 99);
        alloc_pct = (live_heads.size() > 6) ? 40 : 65;
        if (roll < noise_pct) begin
            r = free_req(1'b1, 0);
            if (hammer >= 0) begin
                r.chain_head = HEAD_W'(hammer);
            end else begin
                r.chain_present = ($urandom_range(0, 7) != 0);
                case ($urandom_range(0, 5))
                    0: r.chain_head = HEAD_W'($urandom_range(0, POOL_CELLS - 1));
                    1, 2: if (freed_heads.size() > 0)
                        r.chain_head = freed_heads[$urandom_range(0, freed_heads.size() - 1)];
                    default: r.chain_head = HEAD_W'($urandom_range(0, 1));
                endcase
            end
        end else if (live_heads.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
            r = alloc_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            // Fields an allocation ignores still carry junk now and then.
            if ($urandom_range(0, 3) == 0) begin
                r.chain_present = 1'($urandom_range(0, 1));
                r.chain_head    = HEAD_W'($urandom_range(0, POOL_CELLS - 1));
            end
        end else begin
            idx = $urandom_range(0, live_heads.size() - 1);
            r = free_req(1'b1, live_heads[idx]);
            live_heads.delete(idx);
            if ($urandom_range(0, 3) == 0) begin
                r.want_rgb   = 1'($urandom_range(0, 1));
                r.want_alpha = 1'($urandom_range(0, 1));
                r.want_stw   = 1'($urandom_range(0, 1));
            end
            freed_heads.push_back(r.chain_head);
            if (freed_heads.size() > 32) void'(freed_heads.pop_front());
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_val);
        error_count++;
    endtask

    task automatic queue_request(input cell_req_t r);
        request_q.push_back(r);
        queued_total++;
    endtask

    task automatic wait_for_idle();
        wait (request_q.size() == 0 && results_seen >= queued_total);
    endtask

    task automatic set_pool_limit(input logic [LIMIT_W-1:0] word);
        @(negedge i_clk);
        i_cfg_wdata <= word;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (word == '0)
            pool_cap = LIMIT_W'(1);
        else if (word > NULL_SLOT)
            pool_cap = NULL_SLOT;
        else
            pool_cap = word;
        empty_pool();
        live_heads.delete();
        limit_writes++;
    endtask

    task automatic run_random_phase(input logic [LIMIT_W-1:0] word, input int count,
                                    input int noise_pct, input int hammer);
        set_pool_limit(word);
        repeat (count) begin
            wait (request_q.size() < 2);
            queue_request(pick_request(noise_pct, hammer));
        end
        wait_for_idle();
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (!i_rst_n || gap_left > 0) begin
                if (gap_left > 0) gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
                drive_req = request_q.pop_front();
                s_axis_tuser  <= drive_req.action;
                s_axis_tdata  <= {2'b00, drive_req[13:0]};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a 16-bit stall pattern, redrawn while the test runs.
    always @(negedge i_clk) begin
        ready_tick++;
        if (ready_tick % 64 == 0) begin
            if ($urandom_range(0, 3) == 0)
                stall_pat = '1;
            else
                stall_pat = 16'($urandom()) | 16'h0001;
        end
        m_axis_tready <= i_rst_n && !hold_off && stall_pat[ready_tick % 16];
    end

    // The long hold-off that lets the block fill up and stall its input.
    initial begin
        wait (accepted_total >= 500);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            // Results first, so an item accepted on this edge is never matched here.
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (reply_q.size() == 0) begin
                    report_mismatch("result with nothing pending", m_axis_tdata, 0);
                end else begin
                    oldest   = reply_q.pop_front();
                    got_body = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                    if (m_axis_tuser !== oldest.status)
                        report_mismatch("status", m_axis_tuser, oldest.status);
                    if (got_body.head_valid !== oldest.body.head_valid)
                        report_mismatch("head_valid", got_body.head_valid,
                                        oldest.body.head_valid);
                    if (got_body.head_index !== oldest.body.head_index)
                        report_mismatch("head_index", got_body.head_index,
                                        oldest.body.head_index);
                    if (got_body.chain_length !== oldest.body.chain_length)
                        report_mismatch("chain_length", got_body.chain_length,
                                        oldest.body.chain_length);
                    if (got_body.cells_free !== oldest.body.cells_free)
                        report_mismatch("cells_free", got_body.cells_free,
                                        oldest.body.cells_free);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                accepted_total++;
                bus_req   = {s_axis_tuser, s_axis_tdata[13:0]};
                predicted = serve_request(bus_req);
                reply_q.push_back(predicted);
                if (predicted.body.head_valid && live_heads.size() < HEAD_KEEP)
                    live_heads.push_back(predicted.body.head_index);
                if (bus_req.action == ACT_ALLOC) n_alloc++;
                else n_free++;
                if (predicted.status == ST_NO_CELLS) begin
                    if (predicted.body.chain_length == '0) n_refused++;
                    else n_partial++;
                end
                if (predicted.status == ST_BAD_CELL) n_bad++;
                if (bus_req.action == ACT_FREE && predicted.body.chain_length == MAX_CHAIN)
                    n_capped++;
                if (predicted.body.cells_free == COUNT_MAX) n_saturated++;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("chained_cell_pool_allocator_unit test failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        stall_pat     = '1;
        pool_cap      = NULL_SLOT;
        empty_pool();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pool as left by reset: every group, empty requests, walks and bad heads.
        queue_request(alloc_req(1'b0, 1'b0, 1'b0));
        queue_request(alloc_req(1'b1, 1'b1, 1'b1));
        queue_request(alloc_req(1'b1, 1'b0, 1'b0));
        queue_request(alloc_req(1'b0, 1'b1, 1'b0));
        queue_request(alloc_req(1'b0, 1'b0, 1'b1));
        queue_request(free_req(1'b0, 1023));
        queue_request(free_req(1'b1, 6));
        queue_request(free_req(1'b1, 1023));
        queue_request(free_req(1'b1, 9));
        // Cell 8 sits in the free list already, so this walk would run on past seven cells and is stopped there.
        queue_request(free_req(1'b1, 8));
        queue_request(alloc_req(1'b1, 1'b1, 1'b1));
        queue_request(free_req(1'b1, 13));
        queue_request(free_req(1'b1, 14));
        queue_request(free_req(1'b0, 0));
        wait_for_idle();

        // A zero limit clamps to one cell; repeated frees of it overstate the count
        // until an allocation runs dry part way through its chain.
        set_pool_limit('0);
        queue_request(alloc_req(1'b0, 1'b1, 1'b0));
        queue_request(free_req(1'b1, 0));
        queue_request(free_req(1'b1, 0));
        queue_request(free_req(1'b1, 0));
        queue_request(alloc_req(1'b1, 1'b0, 1'b0));
        queue_request(alloc_req(1'b0, 1'b1, 1'b1));
        queue_request(free_req(1'b1, 5));
        wait_for_idle();

        set_pool_limit('1);
        queue_request(alloc_req(1'b1, 1'b1, 1'b1));
        queue_request(alloc_req(1'b1, 1'b1, 1'b1));
        queue_request(free_req(1'b1, 1023));
        wait_for_idle();

        run_random_phase(LIMIT_W'(12), 200, 8, -1);
        run_random_phase(LIMIT_W'(1024), 200, 6, -1);
        // A single cell freed over and over drives the free count into saturation.
        run_random_phase(LIMIT_W'(1), 400, 95, 0);
        run_random_phase(LIMIT_W'($urandom_range(2, 40)), 200, 10, -1);
        run_random_phase(LIMIT_W'($urandom_range(0, 2047)), 200, 8, -1);
        run_random_phase(LIMIT_W'(7), 200, 12, -1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (reply_q.size() != 0)
            report_mismatch("results never delivered", 0, reply_q.size());

        $display("Ran %0d items (%0d allocations, %0d frees) over %0d pool limit settings.",
                 accepted_total, n_alloc, n_free, limit_writes + 1);
        $display("Refused %0d, cut short %0d, bad cell %0d, walks stopped at seven %0d, %s %0d.",
                 n_refused, n_partial, n_bad, n_capped, "saturated counts", n_saturated);
        if (error_count == 0)
            $display("chained_cell_pool_allocator_unit test passed");
        else
            $display("chained_cell_pool_allocator_unit test failed");
        $finish;
    end

endmodule

// File: files.f
design/ccpa_pkg.sv
design/ccpa_link_ram.sv
design/chained_cell_pool_allocator_unit.sv
tb/tb.sv
